// ===== hdl/rsi_pkg.sv =====
`default_nettype none

package rsi_pkg;

	// coordinate format, fixed by the word layout
	localparam int COORD_WIDTH = 32;

	// multiplier digit handled by one cell of a multiply chain
	localparam int MUL_DIG = 16;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	localparam coord_t COORD_MAX = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
	localparam coord_t COORD_MIN = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});

	typedef enum logic [1:0] {
		CFG_CENTRE_X,
		CFG_CENTRE_Y,
		CFG_CENTRE_Z,
		CFG_RADIUS
	} cfg_idx_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
	} ray_t;

	typedef struct packed {
		logic   hit;
		coord_t distance;
	} result_t;

endpackage

`default_nettype wire

// ===== hdl/rsi_mul.sv =====
`default_nettype none

// unsigned multiplier as a chain of cells, one MUL_DIG-bit multiplier digit per cell
module rsi_mul #(
	parameter int AW  = 33,
	parameter int BW  = 33,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [AW-1:0]  mcand,
	input  logic [BW-1:0]  mplier,
	input  logic [SBW-1:0] sb_in,
	output logic           out_v,
	output logic [AW+BW-1:0] prod,
	output logic [SBW-1:0] sb_out
);
	import rsi_pkg::*;

	localparam int NST  = (BW + MUL_DIG - 1) / MUL_DIG;
	localparam int BPAD = NST * MUL_DIG;
	localparam int PW   = AW + BPAD;

	logic [PW-1:0]   acc_q [NST];
	logic [AW-1:0]   mc_q  [NST];
	logic [BPAD-1:0] mp_q  [NST];
	logic [SBW-1:0]  sb_q  [NST];
	logic            v_q   [NST];

	for (genvar k = 0; k < NST; k++) begin : g_cell
		logic [PW-1:0]          acc_i;
		logic [AW-1:0]          mc_i;
		logic [BPAD-1:0]        mp_i;
		logic [SBW-1:0]         sb_i;
		logic                   v_i;
		logic [AW+MUL_DIG-1:0]  pp;

		if (k == 0) begin : g_head
			assign acc_i = '0;
			assign mc_i  = mcand;
			assign mp_i  = BPAD'(mplier);
			assign sb_i  = sb_in;
			assign v_i   = in_v;
		end else begin : g_link
			assign acc_i = acc_q[k-1];
			assign mc_i  = mc_q[k-1];
			assign mp_i  = mp_q[k-1];
			assign sb_i  = sb_q[k-1];
			assign v_i   = v_q[k-1];
		end

		assign pp = mc_i * mp_i[k*MUL_DIG +: MUL_DIG];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_q[k] <= acc_i + (PW'(pp) << (k * MUL_DIG));
				mc_q[k]  <= mc_i;
				mp_q[k]  <= mp_i;
				sb_q[k]  <= sb_i;
			end
		end
	end

	assign out_v  = v_q[NST-1];
	assign prod   = acc_q[NST-1][AW+BW-1:0];
	assign sb_out = sb_q[NST-1];

endmodule

`default_nettype wire

// ===== hdl/rsi_sqrt.sv =====
`default_nettype none

// floor square root, one root bit per cell
module rsi_sqrt #(
	parameter int DW  = 132,
	parameter int SBW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_v,
	input  logic [DW-1:0]   rad,
	input  logic [SBW-1:0]  sb_in,
	output logic            out_v,
	output logic [DW/2-1:0] root,
	output logic [SBW-1:0]  sb_out
);
	localparam int RW = DW / 2;

	logic [DW-1:0]   rad_q  [RW];
	logic [RW+1:0]   rem_q  [RW];
	logic [RW-1:0]   root_q [RW];
	logic [SBW-1:0]  sb_q   [RW];
	logic            v_q    [RW];

	for (genvar k = 0; k < RW; k++) begin : g_cell
		logic [DW-1:0]  rad_i;
		logic [RW+1:0]  rem_i;
		logic [RW-1:0]  root_i;
		logic [SBW-1:0] sb_i;
		logic           v_i;
		logic [RW+1:0]  rem2;
		logic [RW+1:0]  trial;
		logic           ge;

		if (k == 0) begin : g_head
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign sb_i   = sb_in;
			assign v_i    = in_v;
		end else begin : g_link
			assign rad_i  = rad_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
			assign sb_i   = sb_q[k-1];
			assign v_i    = v_q[k-1];
		end

		// partial remainder stays below 2^RW before each step
		assign rem2  = {rem_i[RW-1:0], rad_i[DW-1 -: 2]};
		assign trial = {root_i, 2'b01};
		assign ge    = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_q[k]  <= rad_i << 2;
				rem_q[k]  <= ge ? rem2 - trial : rem2;
				root_q[k] <= {root_i[RW-2:0], ge};
				sb_q[k]   <= sb_i;
			end
		end
	end

	assign out_v  = v_q[RW-1];
	assign root   = root_q[RW-1];
	assign sb_out = sb_q[RW-1];

endmodule

`default_nettype wire

// ===== hdl/rsi_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cell, MSB first.
// caller guarantees dividend < divisor << QB (overflow handled outside)
module rsi_div #(
	parameter int NW  = 116,
	parameter int DVW = 64,
	parameter int QB  = 31,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [NW-1:0]  dividend,
	input  logic [DVW-1:0] divisor,
	input  logic [SBW-1:0] sb_in,
	output logic           out_v,
	output logic [QB-1:0]  quo,
	output logic [SBW-1:0] sb_out
);
	logic [NW-1:0]  rem_q [QB];
	logic [DVW-1:0] dvs_q [QB];
	logic [QB-1:0]  q_q   [QB];
	logic [SBW-1:0] sb_q  [QB];
	logic           v_q   [QB];

	for (genvar j = 0; j < QB; j++) begin : g_cell
		logic [NW-1:0]  rem_i;
		logic [DVW-1:0] dvs_i;
		logic [QB-1:0]  q_i;
		logic [SBW-1:0] sb_i;
		logic           v_i;
		logic [NW-1:0]  sh;
		logic           ge;

		if (j == 0) begin : g_head
			assign rem_i = dividend;
			assign dvs_i = divisor;
			assign q_i   = '0;
			assign sb_i  = sb_in;
			assign v_i   = in_v;
		end else begin : g_link
			assign rem_i = rem_q[j-1];
			assign dvs_i = dvs_q[j-1];
			assign q_i   = q_q[j-1];
			assign sb_i  = sb_q[j-1];
			assign v_i   = v_q[j-1];
		end

		assign sh = NW'(dvs_i) << (QB - 1 - j);
		assign ge = rem_i >= sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (en) begin
				v_q[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? rem_i - sh : rem_i;
				dvs_q[j] <= dvs_i;
				q_q[j]   <= {q_i[QB-2:0], ge};
				sb_q[j]  <= sb_i;
			end
		end
	end

	assign out_v  = v_q[QB-1];
	assign quo    = q_q[QB-1];
	assign sb_out = sb_q[QB-1];

endmodule

`default_nettype wire

// ===== hdl/ray_sphere_intersect_unit.sv =====
`default_nettype none

// Ray/sphere intersection unit. Each ray word (origin, direction, signed Q16.16) is tested
// against the sphere held in the centre/radius registers; exactly one result word comes back
// per ray, in order: hit=1 with the near distance t = (-b - sqrt(disc)) / a (truncated toward
// zero, saturated to the 32-bit range) when disc = b^2 - a*c > 0, else hit=0 and
// distance = most negative value. A new ray is taken every cycle; the whole pipeline moves
// as one and only holds when the output register is full and res_stall is high. Most of the
// pipeline is the square root chain (one root bit per cell) and the divider chain (one
// quotient bit per cell). Write the registers only while no ray is in flight.
module ray_sphere_intersect_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// ray channel
	input  logic              ray_valid,
	output logic              ray_stall,
	input  rsi_pkg::ray_t     ray,
	// result channel
	output logic              res_valid,
	input  logic              res_stall,
	output rsi_pkg::result_t  res,
	// register writes
	input  logic              cfg_we,
	input  rsi_pkg::cfg_idx_t cfg_idx,
	input  rsi_pkg::coord_t   cfg_data
);
	import rsi_pkg::*;

	localparam int W   = COORD_WIDTH;
	localparam int XW  = W + 1;          // |oc| width
	localparam int PW1 = 2 * XW;         // first product width
	localparam int AWD = 2 * W;          // a, unsigned
	localparam int BWD = 2 * W + 2;      // b, signed
	localparam int CWD = 2 * W + 3;      // c, signed
	localparam int MW2 = 2 * W + 2;      // |b|, |c| operand width
	localparam int PW2 = 2 * MW2;        // second product width
	localparam int DSW = PW2 + 1;        // disc, signed
	localparam int RTW = PW2 / 2;        // sqrt result
	localparam int NMW = 2 * W + 4;      // -b - root, signed
	localparam int MGW = 2 * W + 3;      // |num|
	localparam int NW  = 3 * W + FRAC_BITS + 4;
	localparam int QB  = W - 1;

	// ---------------------------------------------------------------- registers
	coord_t          centre_q [3];
	logic [W-2:0]    radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q[0] <= '0;
			centre_q[1] <= '0;
			centre_q[2] <= '0;
			radius_q    <= (W-1)'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_CENTRE_X: centre_q[0] <= cfg_data;
				CFG_CENTRE_Y: centre_q[1] <= cfg_data;
				CFG_CENTRE_Z: centre_q[2] <= cfg_data;
				CFG_RADIUS:   radius_q    <= cfg_data[W-2:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- flow control
	// single enable for every stage; output register decouples the far side
	logic    en;
	logic    res_valid_q;
	result_t res_q;

	assign en        = !res_valid_q || !res_stall;
	assign ray_stall = !en;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------- s1: oc, magnitudes
	coord_t          ray_o [3];
	coord_t          ray_d [3];
	logic [XW-1:0]   oc_mag_s1 [3];
	logic            oc_sgn_s1 [3];
	logic [W-1:0]    d_mag_s1  [3];
	logic            d_sgn_s1  [3];
	logic [W-2:0]    rad_s1;
	logic            v_s1;

	assign ray_o[0] = ray.origin_x;
	assign ray_o[1] = ray.origin_y;
	assign ray_o[2] = ray.origin_z;
	assign ray_d[0] = ray.dir_x;
	assign ray_d[1] = ray.dir_y;
	assign ray_d[2] = ray.dir_z;

	for (genvar i = 0; i < 3; i++) begin : g_s1
		logic signed [XW-1:0] oc;
		assign oc = XW'(ray_o[i]) - XW'(centre_q[i]);

		always_ff @(posedge clk) begin
			if (en) begin
				oc_sgn_s1[i] <= oc[XW-1];
				oc_mag_s1[i] <= oc[XW-1] ? -oc : oc;
				d_sgn_s1[i]  <= ray_d[i][W-1];
				d_mag_s1[i]  <= ray_d[i][W-1] ? -ray_d[i] : ray_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= radius_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= ray_valid;
		end
	end

	// ---------------------------------------------------------------- first products
	logic [PW1-1:0] p_dd [3];
	logic [PW1-1:0] p_do [3];
	logic [PW1-1:0] p_oo [3];
	logic [PW1-1:0] p_rr;
	logic           do_sgn [3];
	logic           v_m1;

	for (genvar i = 0; i < 3; i++) begin : g_m1
		if (i == 0) begin : g_vtap
			rsi_mul #(.AW(XW), .BW(XW), .SBW(1)) u_dd (
				.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s1),
				.mcand(XW'(d_mag_s1[i])), .mplier(XW'(d_mag_s1[i])), .sb_in(1'b0),
				.out_v(v_m1), .prod(p_dd[i]), .sb_out()
			);
		end else begin : g_nov
			rsi_mul #(.AW(XW), .BW(XW), .SBW(1)) u_dd (
				.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s1),
				.mcand(XW'(d_mag_s1[i])), .mplier(XW'(d_mag_s1[i])), .sb_in(1'b0),
				.out_v(), .prod(p_dd[i]), .sb_out()
			);
		end

		rsi_mul #(.AW(XW), .BW(XW), .SBW(1)) u_do (
			.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s1),
			.mcand(XW'(d_mag_s1[i])), .mplier(oc_mag_s1[i]),
			.sb_in(d_sgn_s1[i] ^ oc_sgn_s1[i]),
			.out_v(), .prod(p_do[i]), .sb_out(do_sgn[i])
		);

		rsi_mul #(.AW(XW), .BW(XW), .SBW(1)) u_oo (
			.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s1),
			.mcand(oc_mag_s1[i]), .mplier(oc_mag_s1[i]), .sb_in(1'b0),
			.out_v(), .prod(p_oo[i]), .sb_out()
		);
	end

	rsi_mul #(.AW(XW), .BW(XW), .SBW(1)) u_rr (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s1),
		.mcand(XW'(rad_s1)), .mplier(XW'(rad_s1)), .sb_in(1'b0),
		.out_v(), .prod(p_rr), .sb_out()
	);

	// ---------------------------------------------------------------- s2: a, b, c
	logic [AWD-1:0]        a_s2;
	logic signed [BWD-1:0] b_s2;
	logic signed [CWD-1:0] c_s2;
	logic                  v_s2;
	logic signed [BWD-1:0] bt [3];

	for (genvar i = 0; i < 3; i++) begin : g_bt
		assign bt[i] = do_sgn[i] ? -BWD'(p_do[i]) : BWD'(p_do[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= AWD'(p_dd[0] + p_dd[1] + p_dd[2]);
			b_s2 <= bt[0] + bt[1] + bt[2];
			c_s2 <= CWD'(p_oo[0]) + CWD'(p_oo[1]) + CWD'(p_oo[2]) - CWD'(p_rr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_m1;
		end
	end

	// ---------------------------------------------------------------- s3: |b|, |c|
	logic [AWD-1:0]        a_s3;
	logic signed [BWD-1:0] b_s3;
	logic [MW2-1:0]        bmag_s3;
	logic [MW2-1:0]        cmag_s3;
	logic                  csgn_s3;
	logic                  v_s3;
	logic signed [CWD-1:0] cneg;

	assign cneg = -c_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= a_s2;
			b_s3    <= b_s2;
			bmag_s3 <= MW2'(b_s2[BWD-1] ? -b_s2 : b_s2);
			csgn_s3 <= c_s2[CWD-1];
			cmag_s3 <= c_s2[CWD-1] ? cneg[MW2-1:0] : c_s2[MW2-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	// ---------------------------------------------------------------- b^2 and a*|c|
	localparam int SB2 = AWD + BWD + 1;

	logic [PW2-1:0]        p_bb;
	logic [PW2-1:0]        p_ac;
	logic [SB2-1:0]        m2_sb;
	logic                  v_m2;
	logic [AWD-1:0]        a_m2;
	logic signed [BWD-1:0] b_m2;
	logic                  csgn_m2;

	rsi_mul #(.AW(MW2), .BW(MW2), .SBW(SB2)) u_bb (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3),
		.mcand(bmag_s3), .mplier(bmag_s3), .sb_in({a_s3, b_s3, csgn_s3}),
		.out_v(v_m2), .prod(p_bb), .sb_out(m2_sb)
	);

	rsi_mul #(.AW(MW2), .BW(MW2), .SBW(1)) u_ac (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s3),
		.mcand(MW2'(a_s3)), .mplier(cmag_s3), .sb_in(1'b0),
		.out_v(), .prod(p_ac), .sb_out()
	);

	assign {a_m2, b_m2, csgn_m2} = m2_sb;

	// ---------------------------------------------------------------- s4: discriminant
	logic [DSW-1:0]        disc;
	logic                  hit_s4;
	logic [PW2-1:0]        disc_s4;
	logic [AWD-1:0]        a_s4;
	logic signed [BWD-1:0] b_s4;
	logic                  v_s4;

	// c < 0 turns -a*c into +a*|c|
	assign disc = csgn_m2 ? DSW'(p_bb) + DSW'(p_ac) : DSW'(p_bb) - DSW'(p_ac);

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4  <= !disc[DSW-1] && (disc != '0) && (a_m2 != '0);
			disc_s4 <= disc[PW2-1:0];
			a_s4    <= a_m2;
			b_s4    <= b_m2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_m2;
		end
	end

	// ---------------------------------------------------------------- square root
	localparam int SB3 = 1 + AWD + BWD;

	logic [RTW-1:0]        root;
	logic [SB3-1:0]        sq_sb;
	logic                  v_sq;
	logic                  hit_sq;
	logic [AWD-1:0]        a_sq;
	logic signed [BWD-1:0] b_sq;

	rsi_sqrt #(.DW(PW2), .SBW(SB3)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s4),
		.rad(disc_s4), .sb_in({hit_s4, a_s4, b_s4}),
		.out_v(v_sq), .root(root), .sb_out(sq_sb)
	);

	assign {hit_sq, a_sq, b_sq} = sq_sb;

	// ---------------------------------------------------------------- s5: -b - root
	logic signed [NMW-1:0] num_s5;
	logic                  hit_s5;
	logic [AWD-1:0]        a_s5;
	logic                  v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s5 <= -NMW'(b_sq) - NMW'(root);
			hit_s5 <= hit_sq;
			a_s5   <= a_sq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_sq;
		end
	end

	// ---------------------------------------------------------------- s6: magnitude
	logic [MGW-1:0] mag_s6;
	logic           neg_s6;
	logic           hit_s6;
	logic [AWD-1:0] a_s6;
	logic           v_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s6 <= num_s5[NMW-1];
			mag_s6 <= MGW'(num_s5[NMW-1] ? -num_s5 : num_s5);
			hit_s6 <= hit_s5;
			a_s6   <= a_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	// ---------------------------------------------------------------- divide
	// quotient at or above 2^(W-1) saturates either way, so the chain only
	// needs W-1 bits
	logic [NW-1:0] dvd;
	logic          ovf;
	logic [QB-1:0] quo;
	logic [2:0]    dv_sb;
	logic          v_dv;
	logic          hit_dv;
	logic          neg_dv;
	logic          ovf_dv;

	assign dvd = NW'(mag_s6) << FRAC_BITS;
	assign ovf = dvd >= (NW'(a_s6) << QB);

	rsi_div #(.NW(NW), .DVW(AWD), .QB(QB), .SBW(3)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_v(v_s6),
		.dividend(dvd), .divisor(a_s6), .sb_in({hit_s6, neg_s6, ovf}),
		.out_v(v_dv), .quo(quo), .sb_out(dv_sb)
	);

	assign {hit_dv, neg_dv, ovf_dv} = dv_sb;

	// ---------------------------------------------------------------- output register
	coord_t t_sat;

	always_comb begin
		if (!hit_dv) begin
			t_sat = COORD_MIN;
		end else if (ovf_dv) begin
			t_sat = neg_dv ? COORD_MIN : COORD_MAX;
		end else if (neg_dv) begin
			t_sat = -coord_t'(quo);
		end else begin
			t_sat = coord_t'(quo);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.hit      <= hit_dv;
			res_q.distance <= t_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_dv;
		end
	end

	// ---------------------------------------------------------------- checks
	a_miss_min: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_q.hit |-> res_q.distance == COORD_MIN)
		else $error("miss word without most negative distance");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!en && v_s1 |=> v_s1)
		else $error("stage 1 word lost while pipeline held");

	a_hit_a: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && hit_s6 |-> a_s6 != '0)
		else $error("hit with zero direction length");

	a_res_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(en))
		else $error("result word appeared without pipeline advance");

endmodule

`default_nettype wire

// ===== tb/sv/tb_ray_sphere_intersect_unit.sv =====
`default_nettype none

module tb_ray_sphere_intersect_unit;
	import rsi_pkg::*;

	localparam int FRAC = 16;
	localparam int DRAIN_CYCLES = 150;   // comfortably above the pipeline depth
	localparam int ONE = 1 << FRAC;

	typedef logic signed [255:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic ray_valid = 1'b0;
	logic ray_stall;
	ray_t ray = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	result_t res;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_idx = CFG_CENTRE_X;
	coord_t cfg_data = '0;

	ray_sphere_intersect_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.ray_valid(ray_valid), .ray_stall(ray_stall), .ray(ray),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// local copy of the sphere registers, tracked on every write
	coord_t sph_cx = '0, sph_cy = '0, sph_cz = '0;
	logic [30:0] sph_r = 31'(ONE);

	result_t hits_due[$];    // predicted result words, oldest first
	int errs = 0;
	bit quiet = 0;           // no idling on either side once set

	// typed expectation travelling with the ray word on the bus
	bit      row_typed = 1'b0;
	result_t row_want = '0;

	// Exact wide-integer ray/sphere test against the tracked sphere.
	function automatic result_t trace_sphere(ray_t r);
		wide_t ox, oy, oz, dx, dy, dz, rad, a, b, c, disc, num, q;
		logic [255:0] root, cand, mag;
		result_t o;
		ox = $signed(r.origin_x); ox = ox - wide_t'(sph_cx);
		oy = $signed(r.origin_y); oy = oy - wide_t'(sph_cy);
		oz = $signed(r.origin_z); oz = oz - wide_t'(sph_cz);
		dx = r.dir_x; dy = r.dir_y; dz = r.dir_z;
		rad = $signed({225'd0, sph_r});
		a = dx*dx + dy*dy + dz*dz;
		b = dx*ox + dy*oy + dz*oz;
		c = ox*ox + oy*oy + oz*oz - rad*rad;
		disc = b*b - a*c;
		o.hit = 1'b0;
		o.distance = COORD_MIN;
		if (disc <= 0 || a == 0)
			return o;
		// floor square root, one bit at a time
		root = '0;
		for (int k = 127; k >= 0; k--) begin
			cand = root | (256'd1 << k);
			if (cand * cand <= disc)
				root = cand;
		end
		num = -b - $signed(root);
		mag = (num < 0) ? -num : num;
		mag = mag << FRAC;
		q = $signed(mag / a);   // truncates toward zero on the magnitude
		if (num < 0)
			q = -q;
		o.hit = 1'b1;
		if (q > wide_t'(COORD_MAX))
			o.distance = COORD_MAX;
		else if (q < wide_t'(COORD_MIN))
			o.distance = COORD_MIN;
		else
			o.distance = q[31:0];
		return o;
	endfunction

	// accepted rays: predict against the register copy at accept time
	always @(posedge clk) begin
		if (arst_n && ray_valid && !ray_stall)
			hits_due.push_back(row_typed ? row_want : trace_sphere(ray));
	end

	// result side: check accepted words, then stall in random bursts
	int stall_left = 0;
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (hits_due.size() == 0) begin
				$error("result word with nothing expected: hit=%0b distance=%0d",
					res.hit, res.distance);
				errs++;
			end else begin
				want = hits_due.pop_front();
				if (res.hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, res.hit);
					errs++;
				end
				if (res.distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, res.distance);
					errs++;
				end
			end
		end
		if (quiet) begin
			stall_left <= 0;
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 2);
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// send one ray word, with an optional idle burst in front of it
	task automatic send_ray(ray_t r);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			ray_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		ray_valid <= 1'b1;
		ray <= r;
		@(posedge clk);
		while (ray_stall) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, coord_t val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_CENTRE_X: sph_cx = val;
			CFG_CENTRE_Y: sph_cy = val;
			CFG_CENTRE_Z: sph_cz = val;
			CFG_RADIUS:   sph_r = val[30:0];
		endcase
	endtask

	// every ray yields a word, so an empty queue means the pipe is empty
	task automatic drain();
		ray_valid <= 1'b0;
		@(posedge clk);
		wait (hits_due.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_sphere(coord_t x, coord_t y, coord_t z, coord_t r);
		drain();
		write_reg(CFG_CENTRE_X, x);
		write_reg(CFG_CENTRE_Y, y);
		write_reg(CFG_CENTRE_Z, z);
		write_reg(CFG_RADIUS, r);
	endtask

	function automatic coord_t spread(int span);
		return coord_t'($urandom_range(0, 2 * span)) - coord_t'(span);
	endfunction

	// mostly rays aimed near the sphere, the rest raw bit noise
	function automatic ray_t random_ray();
		ray_t r;
		int span, sh;
		if ($urandom_range(0, 9) < 7) begin
			span = 4 * int'(sph_r) + ONE;
			if (span > (1 << 26) || span <= 0)
				span = 1 << 26;
			sh = $urandom_range(0, 10);
			r.origin_x = sph_cx + spread(span);
			r.origin_y = sph_cy + spread(span);
			r.origin_z = sph_cz + spread(span);
			r.dir_x = (sph_cx - r.origin_x + spread(span / 4)) >>> sh;
			r.dir_y = (sph_cy - r.origin_y + spread(span / 4)) >>> sh;
			r.dir_z = (sph_cz - r.origin_z + spread(span / 4)) >>> sh;
			if ($urandom_range(0, 7) == 0)
				r.dir_x = -r.dir_x;   // pointing away: far root lies behind
		end else begin
			r = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		end
		return r;
	endfunction

	typedef struct {
		ray_t    r;
		bit      typed;
		result_t want;
	} ray_row_t;

	localparam coord_t FAR = coord_t'(-32000 * ONE);
	localparam coord_t NEAR = coord_t'(32000 * ONE);

	// directed rays against the reset sphere: centre 0, radius 1.0
	ray_row_t ray_rows[] = '{
		'{'{'0, '0, '0, '0, '0, '0}, 1, '{1'b0, COORD_MIN}},              // zero direction
		'{'{FAR, '0, '0, '0, '0, '0}, 1, '{1'b0, COORD_MIN}},
		'{'{coord_t'(-2*ONE), '0, '0, coord_t'(ONE), '0, '0}, 1, '{1'b1, coord_t'(ONE)}},
		'{'{'0, '0, '0, coord_t'(ONE), '0, '0}, 1, '{1'b1, coord_t'(-ONE)}},     // inside
		'{'{coord_t'(-2*ONE), coord_t'(ONE), '0, coord_t'(ONE), '0, '0},
			1, '{1'b0, COORD_MIN}},                                          // tangent
		'{'{coord_t'(-2*ONE), coord_t'(2*ONE), '0, coord_t'(ONE), '0, '0},
			1, '{1'b0, COORD_MIN}},                                          // clear miss
		'{'{FAR, '0, '0, coord_t'(1), '0, '0}, 1, '{1'b1, COORD_MAX}},    // saturate high
		'{'{NEAR, '0, '0, coord_t'(1), '0, '0}, 1, '{1'b1, COORD_MIN}},   // saturate low
		'{'{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX}, 0, '0},
		'{'{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN}, 0, '0},
		'{'{COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN}, 0, '0},
		'{'{COORD_MIN, '0, '0, COORD_MAX, '0, '0}, 0, '0},
		'{'{COORD_MAX, '0, '0, COORD_MIN, '0, '0}, 0, '0},
		'{'{coord_t'(-5*ONE), coord_t'(-3), coord_t'(7), coord_t'(3*ONE),
			coord_t'(1), coord_t'(-1)}, 0, '0},
		'{'{coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1),
			coord_t'(-1)}, 0, '0}
	};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// typed rows ride alongside the ray word and replace the prediction
		foreach (ray_rows[i]) begin
			row_typed <= ray_rows[i].typed;
			row_want <= ray_rows[i].want;
			send_ray(ray_rows[i].r);
		end
		row_typed <= 1'b0;

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_sphere(coord_t'(3*ONE), coord_t'(-2*ONE), coord_t'(ONE / 2),
					coord_t'(2*ONE));
				1: set_sphere(COORD_MAX, COORD_MIN, COORD_MAX, coord_t'(0));
				2: set_sphere(COORD_MIN, COORD_MAX, COORD_MIN, {1'b0, {31{1'b1}}});
				3: set_sphere(spread(1 << 28), spread(1 << 28), spread(1 << 28),
					coord_t'($urandom_range(1, 1 << 22)));
				4: set_sphere('0, '0, '0, coord_t'($urandom_range(1, 1 << 12)));
				default: begin
					set_sphere(spread(1 << 24), spread(1 << 24), spread(1 << 24),
						coord_t'($urandom_range(ONE, 1 << 24)));
					quiet = 1;
				end
			endcase
			repeat (240) send_ray(random_ray());
		end

		ray_valid <= 1'b0;
		wait (hits_due.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errs == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#6000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/rsi_pkg.sv
hdl/rsi_mul.sv
hdl/rsi_sqrt.sv
hdl/rsi_div.sv
hdl/ray_sphere_intersect_unit.sv
tb/sv/tb_ray_sphere_intersect_unit.sv
